FILE: rtl/core/lpsd_pkg.sv
// Package for the long-press standby detector: widths, register map,
// reset values, phase codes and the structs passed between the core modules.
// No dependencies.
package lpsd_pkg;

    // Run-length counter of unchanged raw samples, saturating
    localparam int RUN_W = 16;
    localparam logic [RUN_W-1:0] RUN_MAX = 16'hFFFF;

    // Press counter. Every threshold is 16 bits wide, so a 17-bit counter
    // that saturates at all ones compares exactly like a 31-bit one.
    localparam int PRESS_W = 17;
    localparam logic [PRESS_W-1:0] PRESS_MAX = 17'h1FFFF;

    // Configuration port
    localparam int CFG_AW  = 4;
    localparam int CFG_DW  = 32;
    localparam int THR_W   = 16;

    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_HOLD     = 2'd1;
    localparam logic [1:0] REG_BUZZER   = 2'd2;
    localparam logic [1:0] REG_RELEASE  = 2'd3;

    localparam logic [THR_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [THR_W-1:0] HOLD_RST     = 16'd1000;
    localparam logic [THR_W-1:0] BUZZER_RST   = 16'd300;
    localparam logic [THR_W-1:0] RELEASE_RST  = 16'd50;

    // Reported phase codes
    localparam int PHASE_W = 2;
    localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
    localparam logic [PHASE_W-1:0] PH_HOLDING = 2'd1;
    localparam logic [PHASE_W-1:0] PH_ARMED   = 2'd2;

    // Threshold registers
    typedef struct packed {
        logic [THR_W-1:0] debounce_ticks;
        logic [THR_W-1:0] hold_ticks;
        logic [THR_W-1:0] buzzer_ticks;
        logic [THR_W-1:0] release_ticks;
    } t_cfg;

    // Debounce stage result for the current tick
    typedef struct packed {
        logic             raw;
        logic             level;
        logic [RUN_W-1:0] run_count;
    } t_deb;

    // State machine result for the current tick
    typedef struct packed {
        logic               buzzer_request;
        logic               standby_request;
        logic               clr_run;
        logic [PHASE_W-1:0] phase;
    } t_fsm;

endpackage

FILE: rtl/core/lpsd_in_if.sv
// Request channel carrying one raw button sample per tick.
// No dependencies.
interface lpsd_in_if;
    logic valid;
    logic ready;
    logic raw_pressed;

    modport source (output valid, output raw_pressed, input ready);
    modport sink   (input valid, input raw_pressed, output ready);
endinterface

FILE: rtl/core/lpsd_out_if.sv
// Result channel carrying the debounced level, requests and phase per tick.
// Depends on lpsd_pkg.
interface lpsd_out_if;
    import lpsd_pkg::*;

    logic               valid;
    logic               ready;
    logic               debounced_pressed;
    logic               buzzer_request;
    logic               standby_request;
    logic [PHASE_W-1:0] phase;

    modport source (output valid, output debounced_pressed, output buzzer_request,
                    output standby_request, output phase, input ready);
    modport sink   (input valid, input debounced_pressed, input buzzer_request,
                    input standby_request, input phase, output ready);
endinterface

FILE: rtl/core/lpsd_cfg_regs.sv
// APB-style threshold register file for the long-press standby detector.
// Depends on lpsd_pkg.
module lpsd_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lpsd_pkg::CFG_AW-1:0] paddr,
    input  logic [lpsd_pkg::CFG_DW-1:0] pwdata,
    output logic [lpsd_pkg::CFG_DW-1:0] prdata,
    output logic                        pready,
    output lpsd_pkg::t_cfg              o_cfg
);
    import lpsd_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    // Register writes, word aligned
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= DEBOUNCE_RST;
            r_cfg.hold_ticks     <= HOLD_RST;
            r_cfg.buzzer_ticks   <= BUZZER_RST;
            r_cfg.release_ticks  <= RELEASE_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_DEBOUNCE: r_cfg.debounce_ticks <= pwdata[THR_W-1:0];
                REG_HOLD:     r_cfg.hold_ticks     <= pwdata[THR_W-1:0];
                REG_BUZZER:   r_cfg.buzzer_ticks   <= pwdata[THR_W-1:0];
                REG_RELEASE:  r_cfg.release_ticks  <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux, zero extended
    always_comb begin
        case (reg_idx)
            REG_DEBOUNCE: prdata = {{(CFG_DW-THR_W){1'b0}}, r_cfg.debounce_ticks};
            REG_HOLD:     prdata = {{(CFG_DW-THR_W){1'b0}}, r_cfg.hold_ticks};
            REG_BUZZER:   prdata = {{(CFG_DW-THR_W){1'b0}}, r_cfg.buzzer_ticks};
            REG_RELEASE:  prdata = {{(CFG_DW-THR_W){1'b0}}, r_cfg.release_ticks};
            default:      prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/lpsd_debounce.sv
// Run-length debouncer: tracks unchanged raw samples and the debounced level.
// Depends on lpsd_pkg.
module lpsd_debounce (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic                       i_raw,
    input  logic [lpsd_pkg::THR_W-1:0] i_debounce_ticks,
    input  logic                       i_clr_run,
    output lpsd_pkg::t_deb             o_deb
);
    import lpsd_pkg::*;

    logic             r_last_raw;
    logic [RUN_W-1:0] r_run;
    logic             r_level;
    logic [RUN_W-1:0] n_run;
    logic             n_level;

    // Saturating run count, restarts on any raw change
    always_comb begin
        if (i_raw == r_last_raw) begin
            n_run = (r_run == RUN_MAX) ? r_run : r_run + 1'b1;
        end else begin
            n_run = '0;
        end
        n_level = (n_run == i_debounce_ticks) ? i_raw : r_level;
    end

    assign o_deb.raw       = i_raw;
    assign o_deb.level     = n_level;
    assign o_deb.run_count = n_run;

    // State update once per tick; the state machine may clear the run count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw <= 1'b0;
            r_run      <= '0;
            r_level    <= 1'b0;
        end else if (i_step) begin
            r_last_raw <= i_raw;
            r_run      <= i_clr_run ? '0 : n_run;
            r_level    <= n_level;
        end
    end

endmodule

FILE: rtl/core/lpsd_fsm.sv
// Idle / holding / armed state machine with press counter, buzzer and
// standby requests. Depends on lpsd_pkg.
module lpsd_fsm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  lpsd_pkg::t_deb i_deb,
    input  lpsd_pkg::t_cfg i_cfg,
    output lpsd_pkg::t_fsm o_fsm
);
    import lpsd_pkg::*;

    typedef enum logic [PHASE_W-1:0] {
        S_IDLE    = PH_IDLE,
        S_HOLDING = PH_HOLDING,
        S_ARMED   = PH_ARMED
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [PRESS_W-1:0] r_press;
    logic [PRESS_W-1:0] n_press;
    logic [PRESS_W-1:0] press_inc;
    logic               buzz;
    logic               stby;
    logic               clr_run;

    assign press_inc = (r_press == PRESS_MAX) ? r_press : r_press + 1'b1;

    // Next state and per-tick requests
    always_comb begin
        n_state = r_state;
        n_press = r_press;
        buzz    = 1'b0;
        stby    = 1'b0;
        clr_run = 1'b0;
        case (r_state)
            S_HOLDING: begin
                if (!i_deb.level) begin
                    n_state = S_ARMED;
                    clr_run = 1'b1;
                end
            end
            S_ARMED: begin
                if (!i_deb.level) begin
                    stby = (i_deb.run_count >= i_cfg.release_ticks) && !i_deb.raw;
                end else begin
                    n_state = S_IDLE;
                    n_press = '0;
                end
            end
            default: begin
                // idle, and the unused code behaves as idle
                n_state = S_IDLE;
                if (i_deb.level) begin
                    n_press = press_inc;
                    buzz    = press_inc >= {1'b0, i_cfg.buzzer_ticks};
                    if (press_inc >= {1'b0, i_cfg.hold_ticks}) begin
                        n_state = S_HOLDING;
                    end
                end else begin
                    n_press = '0;
                end
            end
        endcase
    end

    assign o_fsm.buzzer_request  = buzz;
    assign o_fsm.standby_request = stby;
    assign o_fsm.clr_run         = clr_run;
    assign o_fsm.phase           = n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_press <= '0;
        end else if (i_step) begin
            r_state <= n_state;
            r_press <= n_press;
        end
    end

endmodule

FILE: rtl/core/long_press_standby_detector_core.sv
// Top level of the long-press standby detector: input stage, debouncer,
// state machine, result register and threshold registers.
// Depends on lpsd_pkg, lpsd_in_if, lpsd_out_if, lpsd_cfg_regs, lpsd_debounce, lpsd_fsm.
//
//   channel   | dir | payload                                             | handshake
//   ----------+-----+-----------------------------------------------------+--------------
//   i_in      | in  | raw_pressed                                         | valid/ready
//   o_out     | out | debounced_pressed, buzzer_request, standby_request, | valid/ready
//             |     | phase                                               |
//   APB cfg   | in  | paddr, pwdata (writes), prdata (reads)              | psel/penable
//
// One request per cycle is accepted while the result is not stalled; each
// result passes through the input register, then the result register.
// All per-tick work is one pass of counter, compare and state logic between
// the input register and the result register.
// Reset is synchronous, active low; thresholds return to their defaults.
// A stalled result holds the result register; the input register still
// takes one more request, after which ready drops until the result moves.
module long_press_standby_detector_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    lpsd_in_if.sink                     i_in,
    lpsd_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lpsd_pkg::CFG_AW-1:0] paddr,
    input  logic [lpsd_pkg::CFG_DW-1:0] pwdata,
    output logic [lpsd_pkg::CFG_DW-1:0] prdata,
    output logic                        pready
);
    import lpsd_pkg::*;

    t_cfg               cfg;
    t_deb               deb;
    t_fsm               fsm;
    logic               r_in_valid;
    logic               r_raw;
    logic               r_out_valid;
    logic               r_out_level;
    logic               r_out_buzz;
    logic               r_out_stby;
    logic [PHASE_W-1:0] r_out_phase;
    logic               advance;
    logic               step;

    // Pipeline control
    assign advance    = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    lpsd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lpsd_debounce u_deb (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (step),
        .i_raw            (r_raw),
        .i_debounce_ticks (cfg.debounce_ticks),
        .i_clr_run        (fsm.clr_run),
        .o_deb            (deb)
    );

    lpsd_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_deb   (deb),
        .i_cfg   (cfg),
        .o_fsm   (fsm)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_raw <= i_in.raw_pressed;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (step) begin
            r_out_level <= deb.level;
            r_out_buzz  <= fsm.buzzer_request;
            r_out_stby  <= fsm.standby_request;
            r_out_phase <= fsm.phase;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.debounced_pressed = r_out_level;
    assign o_out.buzzer_request    = r_out_buzz;
    assign o_out.standby_request   = r_out_stby;
    assign o_out.phase             = r_out_phase;

    // Buzzer only from idle while pressed, so never reported together with armed
    a_buzz_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.buzzer_request) |->
        (o_out.debounced_pressed && o_out.phase != PH_ARMED))
        else $error("buzzer request outside idle press");

    // Standby only while armed and released
    a_stby_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.standby_request) |->
        (o_out.phase == PH_ARMED && !o_out.debounced_pressed))
        else $error("standby request outside armed release");

    // A full, stalled pipeline takes no new request
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |-> !(i_in.valid && i_in.ready))
        else $error("request accepted into full pipeline");

    // A stalled result does not lose the tick behind it
    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("input stage dropped a pending request");

endmodule

FILE: tb/sv/lpsd_tb_pkg.sv
`timescale 1ns / 100ps
// Tick tracker for the long-press standby detector testbench: threshold copy,
// debounce and phase prediction, queue of expected per-tick results.
// Depends on lpsd_pkg.
package lpsd_tb_pkg;
    import lpsd_pkg::*;

    localparam logic [30:0] PRESS_LIMIT = 31'h7FFF_FFFF;

    typedef struct packed {
        logic               debounced_pressed;
        logic               buzzer_request;
        logic               standby_request;
        logic [PHASE_W-1:0] phase;
    } t_tick_result;

    class standby_tick_tracker;
        // thresholds as last written
        logic [THR_W-1:0] debounce_ticks;
        logic [THR_W-1:0] hold_ticks;
        logic [THR_W-1:0] buzzer_ticks;
        logic [THR_W-1:0] release_ticks;

        // detector state
        logic               last_raw;
        logic [RUN_W-1:0]   run_count;
        logic               level_pressed;
        logic [30:0]        press_count;
        logic [PHASE_W-1:0] fsm_phase;

        t_tick_result expected_ticks[$];
        int           errors;

        function new();
            debounce_ticks = DEBOUNCE_RST;
            hold_ticks     = HOLD_RST;
            buzzer_ticks   = BUZZER_RST;
            release_ticks  = RELEASE_RST;
            last_raw       = 1'b0;
            run_count      = '0;
            level_pressed  = 1'b0;
            press_count    = '0;
            fsm_phase      = PH_IDLE;
            errors         = 0;
        endfunction

        function void set_threshold(logic [1:0] idx, logic [THR_W-1:0] value);
            case (idx)
                REG_DEBOUNCE: debounce_ticks = value;
                REG_HOLD:     hold_ticks     = value;
                REG_BUZZER:   buzzer_ticks   = value;
                REG_RELEASE:  release_ticks  = value;
                default:      ;
            endcase
        endfunction

        // Advance the detector by one accepted tick and queue its result
        function void predict_tick(logic raw);
            t_tick_result res;
            res = '0;

            // run length of the raw level, debounced level update
            if (raw == last_raw) begin
                if (run_count != RUN_MAX) run_count++;
            end else begin
                run_count = '0;
                last_raw  = raw;
            end
            if (run_count == debounce_ticks) level_pressed = raw;

            // phase machine; the unused code falls into idle
            case (fsm_phase)
                PH_HOLDING: begin
                    if (!level_pressed) begin
                        fsm_phase = PH_ARMED;
                        run_count = '0;
                    end
                end
                PH_ARMED: begin
                    if (!level_pressed) begin
                        if (run_count >= release_ticks && !raw) res.standby_request = 1'b1;
                    end else begin
                        fsm_phase   = PH_IDLE;
                        press_count = '0;
                    end
                end
                default: begin
                    fsm_phase = PH_IDLE;
                    if (level_pressed) begin
                        if (press_count != PRESS_LIMIT) press_count++;
                        if (press_count >= buzzer_ticks) res.buzzer_request = 1'b1;
                        if (press_count >= hold_ticks) fsm_phase = PH_HOLDING;
                    end else begin
                        press_count = '0;
                    end
                end
            endcase

            res.debounced_pressed = level_pressed;
            res.phase             = fsm_phase;
            expected_ticks.push_back(res);
        endfunction

        function void check_result(logic deb, logic buzz, logic stby, logic [PHASE_W-1:0] ph);
            t_tick_result got;
            t_tick_result want;
            got = {deb, buzz, stby, ph};
            if (expected_ticks.size() == 0) begin
                errors++;
                $display("%0t: no request outstanding, got deb=%0b buzz=%0b stby=%0b ph=%0d",
                         $time, deb, buzz, stby, ph);
                return;
            end
            want = expected_ticks.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: expected %0b %0b %0b %0d, got %0b %0b %0b %0d",
                         $time, want.debounced_pressed, want.buzzer_request,
                         want.standby_request, want.phase, deb, buzz, stby, ph);
            end
        endfunction

        function int outstanding();
            return expected_ticks.size();
        endfunction
    endclass

endpackage

FILE: tb/sv/tb_long_press_standby_detector_core.sv
`timescale 1ns / 100ps
// Testbench top for long_press_standby_detector_core: drives button ticks,
// APB threshold writes and result back-pressure, checks every result.
// Depends on lpsd_pkg, lpsd_tb_pkg, lpsd_in_if, lpsd_out_if and the core RTL.
module tb_long_press_standby_detector_core;
    import lpsd_pkg::*;
    import lpsd_tb_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLDOFF_CYCLES = 150;
    localparam int LONG_RUN_TICKS = 40;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_TICKS    = 100;
    localparam int TIMEOUT_NS     = 4_000_000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    lpsd_in_if  in_if();
    lpsd_out_if out_if();

    long_press_standby_detector_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    standby_tick_tracker tracker = new();

    int send_idle_pct = 0;
    int rcv_stall_pct = 0;
    int holdoff_reqs  = 0;

    // clock
    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) tracker.predict_tick(in_if.raw_pressed);
            if (out_if.valid && out_if.ready)
                tracker.check_result(out_if.debounced_pressed, out_if.buzzer_request,
                                     out_if.standby_request, out_if.phase);
        end
    end

    // result back-pressure: random stalls, plus long hold-offs on request
    initial begin
        int hold_left;
        int seen_reqs;
        hold_left = 0;
        seen_reqs = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (seen_reqs != holdoff_reqs) begin
                seen_reqs = holdoff_reqs;
                hold_left = HOLDOFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    function automatic int capped(int v, int cap);
        return (v > cap) ? cap : v;
    endfunction

    // one raw sample; entered and left at a falling edge
    task automatic send_tick(input logic raw);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid       <= 1'b0;
            in_if.raw_pressed <= 1'($urandom_range(1));
            @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.raw_pressed <= raw;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    // a run of one level, each tick flipped with the given odds
    task automatic send_run(input logic level, input int ticks, input int glitch_pct);
        for (int k = 0; k < ticks; k++)
            send_tick(($urandom_range(99) < glitch_pct) ? !level : level);
    endtask

    // fixed pattern, sent MSB first
    task automatic send_bits(input logic [31:0] bits, input int n);
        for (int k = n - 1; k >= 0; k--) send_tick(bits[k]);
    endtask

    // stop requests and wait until every result is back
    task automatic settle();
        in_if.valid <= 1'b0;
        while (tracker.outstanding() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // APB write: setup, access, then psel low again
    task automatic apb_write(input logic [1:0] idx, input logic [THR_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom_range(16'hFFFF)), value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_threshold(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic program_thresholds(input int deb, input int hold, input int buzz,
                                      input int rel);
        apb_write(REG_DEBOUNCE, THR_W'(deb));
        apb_write(REG_HOLD,     THR_W'(hold));
        apb_write(REG_BUZZER,   THR_W'(buzz));
        apb_write(REG_RELEASE,  THR_W'(rel));
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1:       begin send_idle_pct = 68; rcv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rcv_stall_pct = 68; end
            3:       begin send_idle_pct = 32; rcv_stall_pct = 32; end
            default: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
        endcase
    endtask

    // press/hold/release cycles with random lengths, glitches and noise
    task automatic random_phase(input int ticks);
        int deb;
        int glitch;
        for (int sent = 0; sent < ticks; ) begin
            deb    = capped(int'(tracker.debounce_ticks), 8);
            glitch = $urandom_range(1) ? 0 : 8;
            if ($urandom_range(99) < 80) begin
                int press_len;
                int rel_len;
                press_len = deb + capped(int'(tracker.hold_ticks), 40) + $urandom_range(8);
                if ($urandom_range(1)) press_len = $urandom_range(press_len);
                rel_len = deb + capped(int'(tracker.release_ticks), 30) + $urandom_range(12);
                send_run(1'b1, press_len, glitch);
                send_run(1'b0, rel_len, glitch);
                sent += press_len + rel_len;
                // short re-press while armed
                if ($urandom_range(99) < 30) begin
                    press_len = deb + $urandom_range(3);
                    send_run(1'b1, press_len, 0);
                    sent += press_len;
                end
            end else begin
                int noise_len;
                noise_len = 1 + $urandom_range(11);
                send_run(1'b0, noise_len, 50);
                sent += noise_len;
            end
        end
    endtask

    // main sequence
    initial begin
        int hold;
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.raw_pressed = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset thresholds: short bounces never reach the debounce count
        send_bits(32'b110, 3);
        settle();

        // hold zero: first pressed idle tick goes to holding; repeated standby
        program_thresholds(0, 0, 0, 2);
        send_bits(32'b1100001100, 10);
        settle();

        // debounce of two with glitches while armed
        program_thresholds(2, 3, 2, 1);
        send_bits(32'b1111100010, 10);
        settle();

        // hold and buzzer at their maximum: a long press reaches neither
        program_thresholds(0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_run(1'b0, 4, 0);
        send_run(1'b1, LONG_RUN_TICKS, 0);
        send_run(1'b0, 20, 0);
        settle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0:       program_thresholds(0, 1, 0, 0);
                5:       program_thresholds(16'hFFFF, 1 + $urandom_range(20),
                                            $urandom_range(20), $urandom_range(10));
                7:       program_thresholds($urandom_range(4), 1 + $urandom_range(20),
                                            16'hFFFF, 16'hFFFF);
                default: begin
                    hold = 1 + $urandom_range(24);
                    program_thresholds($urandom_range(6), hold, $urandom_range(30),
                                       $urandom_range(15));
                end
            endcase
            set_idling(ph % 4);
            // long result hold-off while requests keep coming
            if (ph % 4 == 0) holdoff_reqs++;
            random_phase(PHASE_TICKS);
            settle();
        end

        if (tracker.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: long_press_standby_detector_core.f
rtl/core/lpsd_pkg.sv
rtl/core/lpsd_in_if.sv
rtl/core/lpsd_out_if.sv
rtl/core/lpsd_cfg_regs.sv
rtl/core/lpsd_debounce.sv
rtl/core/lpsd_fsm.sv
rtl/core/long_press_standby_detector_core.sv
tb/sv/lpsd_tb_pkg.sv
tb/sv/tb_long_press_standby_detector_core.sv
